### sv/chr_pkg.sv
// Shared types and codes for the consistent hash ring.
package chr_pkg;

   localparam int ID_W   = 20;
   localparam int HASH_W = 32;
   localparam int OP_W   = 2;
   localparam int ST_W   = 2;

   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

   localparam logic [ST_W-1:0] ST_OK        = 2'd0;
   localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [ST_W-1:0] ST_EMPTY     = 2'd2;
   localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

   // one ring entry as held in a cell
   typedef struct packed {
      logic              valid;
      logic [HASH_W-1:0] hash;
      logic [ID_W-1:0]   server;
   } chr_entry_type;

   // command broadcast to every cell
   typedef struct packed {
      logic              add_en;
      logic              rem_en;
      logic [HASH_W-1:0] hash;
      logic [ID_W-1:0]   id;
   } chr_cmd_type;

   // signals rippling from cell to cell towards the high end
   typedef struct packed {
      logic            ins;
      logic            gt;
      logic            match;
      logic [ID_W-1:0] pick;
   } chr_link_type;

endpackage

### sv/chr_req_if.sv
// Request channel: operation, server id and hash.
interface chr_req_if
   import chr_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   opcode;
   logic [ID_W-1:0]   node_id;
   logic [HASH_W-1:0] key_hash;

   modport source (output valid, output opcode, output node_id, output key_hash,
                   input ready);
   modport sink   (input valid, input opcode, input node_id, input key_hash,
                   output ready);
endinterface

### sv/chr_rsp_if.sv
// Response channel: chosen server and status.
interface chr_rsp_if
   import chr_pkg::*;
   ();
   logic            valid;
   logic            ready;
   logic [ID_W-1:0] chosen_server;
   logic [ST_W-1:0] status;

   modport source (output valid, output chosen_server, output status, input ready);
   modport sink   (input valid, input chosen_server, input status, output ready);
endinterface

### sv/chr_cell.sv
// One ring slot: holds an entry, shifts up on add and down on remove.
module chr_cell
   import chr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  chr_cmd_type   cmd,
   input  chr_entry_type prev_entry,
   input  chr_entry_type next_entry,
   input  chr_link_type  link_in,
   output chr_entry_type entry,
   output chr_link_type  link_out
);

   logic              valid_ff;
   logic              valid_in;
   logic [HASH_W-1:0] hash_ff;
   logic [HASH_W-1:0] hash_in;
   logic [ID_W-1:0]   server_ff;
   logic [ID_W-1:0]   server_in;
   logic              lt;
   logic              ins;
   logic              gt;
   logic              match;
   logic              first_gt;

   assign lt       = cmd.hash < hash_ff;
   assign ins      = !valid_ff || lt;
   assign gt       = valid_ff && lt;
   assign match    = link_in.match || (valid_ff && (server_ff == cmd.id));
   assign first_gt = gt && !link_in.gt;

   // gt carries "some slot at or below here holds a larger hash"
   assign link_out.ins   = ins;
   assign link_out.gt    = link_in.gt || gt;
   assign link_out.match = match;
   assign link_out.pick  = link_in.pick | (first_gt ? server_ff : '0);

   assign entry.valid  = valid_ff;
   assign entry.hash   = hash_ff;
   assign entry.server = server_ff;

   always_comb begin
      valid_in  = valid_ff;
      hash_in   = hash_ff;
      server_in = server_ff;
      if (cmd.add_en) begin
         // insertion point is the first slot that is empty or holds a larger hash
         if (link_in.ins) begin
            valid_in  = prev_entry.valid;
            hash_in   = prev_entry.hash;
            server_in = prev_entry.server;
         end else if (ins) begin
            valid_in  = 1'b1;
            hash_in   = cmd.hash;
            server_in = cmd.id;
         end
      end else if (cmd.rem_en && match) begin
         valid_in  = next_entry.valid;
         hash_in   = next_entry.hash;
         server_in = next_entry.server;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      hash_ff   <= hash_in;
      server_ff <= server_in;
   end

endmodule

### sv/consistent_hash_ring_core.sv
// Consistent hash ring top level: a row of slot cells and a response register.
// The response is registered: it goes valid in the cycle after request accept.
// Throughput: one request per cycle unless a held response stalls; each op updates
// every cell in the same cycle (critical path: first-match ripple over RING_SLOTS).
// Reset: synchronous; empties the ring and drops any pending response.
module consistent_hash_ring_core
   import chr_pkg::*;
#(
   parameter int RING_SLOTS = 16
)
(
   input logic      clock,
   input logic      reset,
   chr_req_if.sink   req_ch,
   chr_rsp_if.source rsp_ch
);

   chr_entry_type entries [RING_SLOTS+1];
   chr_link_type  links   [RING_SLOTS+1];
   chr_entry_type edge_entry;
   chr_cmd_type   cmd;

   logic            fire;
   logic            full;
   logic            empty;
   logic            found;
   logic            is_add;
   logic            is_rem;
   logic            is_lookup;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic [ID_W-1:0] chosen_ff;
   logic [ID_W-1:0] chosen_in;
   logic [ST_W-1:0] status_ff;
   logic [ST_W-1:0] status_in;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign fire         = req_ch.valid && req_ch.ready;

   assign is_add    = req_ch.opcode == OP_ADD;
   assign is_rem    = req_ch.opcode == OP_REMOVE;
   assign is_lookup = req_ch.opcode == OP_LOOKUP;

   assign empty = !entries[1].valid;
   assign full  = entries[RING_SLOTS].valid;
   assign found = links[RING_SLOTS].match;

   assign cmd.add_en = fire && is_add && !full;
   assign cmd.rem_en = fire && is_rem && found;
   assign cmd.hash   = req_ch.key_hash;
   assign cmd.id     = req_ch.node_id;

   assign edge_entry = '0;
   assign links[0]   = '0;

   // entries[k] is cell k-1; entries[0] stands for the empty slot below cell 0
   assign entries[0] = edge_entry;

   for (genvar i = 0; i < RING_SLOTS; i++) begin : g_cell
      chr_entry_type next_entry;

      if (i == RING_SLOTS - 1) begin : g_top
         assign next_entry = edge_entry;
      end else begin : g_mid
         assign next_entry = entries[i+2];
      end

      chr_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .prev_entry (entries[i]),
         .next_entry (next_entry),
         .link_in    (links[i]),
         .entry      (entries[i+1]),
         .link_out   (links[i+1])
      );
   end

   always_comb begin
      chosen_in = '0;
      status_in = ST_OK;
      if (is_add) begin
         status_in = full ? ST_FULL : ST_OK;
      end else if (is_rem) begin
         status_in = found ? ST_OK : ST_NOT_FOUND;
      end else if (is_lookup) begin
         if (empty) begin
            status_in = ST_EMPTY;
         end else if (links[RING_SLOTS].gt) begin
            chosen_in = links[RING_SLOTS].pick;
         end else begin
            // no hash above the key: wrap to the first entry
            chosen_in = entries[1].server;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (fire) begin
         chosen_ff <= chosen_in;
         status_ff <= status_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.chosen_server = chosen_ff;
   assign rsp_ch.status        = status_ff;

endmodule
